@@ sv/hsvcc_pkg.sv @@
// Shared constants, codes and types of the HSV color classifier.
package hsvcc_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int PIXEL_BITS   = 24;

	// Hue limits in degrees, inclusive.
	localparam int HUE_YELLOW_LO = 39;
	localparam int HUE_YELLOW_HI = 70;
	localparam int HUE_BLUE_LO   = 200;
	localparam int HUE_BLUE_HI   = 275;
	localparam int HUE_ORANGE_LO = 7;
	localparam int HUE_ORANGE_HI = 28;
	localparam int HUE_WRAP      = 360;
	localparam int HUE_GREEN_BASE = 120;
	localparam int HUE_BLUE_BASE  = 240;
	localparam int HUE_SECTOR     = 60;

	typedef enum logic [1:0] {
		CLS_UNKNOWN = 2'd0,
		CLS_YELLOW  = 2'd1,
		CLS_BLUE    = 2'd2,
		CLS_ORANGE  = 2'd3
	} color_class_t;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// Saturation and value tests, already resolved per class.
	typedef struct packed {
		logic nonzero;    // delta above zero
		logic sat_hi;     // S >= 0.6
		logic sat_mid;    // S >= 0.5
		logic val_yellow; // V >= 0.4
		logic val_blue;   // V >= 0.15
		logic val_orange; // V >= 0.3
	} gate_t;

endpackage

@@ sv/hsvcc_pixel_if.sv @@
// Valid/ready channel that carries one packed pixel.
interface hsvcc_pixel_if;
	logic                              valid;
	logic                              ready;
	logic [hsvcc_pkg::PIXEL_BITS-1:0]  pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

@@ sv/hsvcc_class_if.sv @@
// Valid/ready channel that carries one color class result.
interface hsvcc_class_if;
	logic       valid;
	logic       ready;
	logic [1:0] color_class;

	modport source (output valid, output color_class, input ready);
	modport sink   (input valid, input color_class, output ready);
endinterface

@@ sv/hsvcc_extrema.sv @@
// Stage 1: channel split, max/min, delta, hue sector and sector difference.
module hsvcc_extrema #(
	parameter int CHANNEL_BITS = hsvcc_pkg::CHANNEL_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   valid_in,
	input  logic [hsvcc_pkg::PIXEL_BITS-1:0]       pixel,
	output logic                                   valid_s1,
	output logic [CHANNEL_BITS-1:0]                mx_s1,
	output logic [CHANNEL_BITS-1:0]                d_s1,
	output logic signed [CHANNEL_BITS:0]           diff_s1,
	output hsvcc_pkg::sector_t                     sector_s1
);
	localparam int W  = CHANNEL_BITS;
	localparam int PB = hsvcc_pkg::PIXEL_BITS;

	logic [3*W+PB-1:0]   px_wide;
	logic [3*W-1:0]      px;
	logic [W-1:0]        r, g, b, mx, mn;
	logic signed [W:0]   diff;
	hsvcc_pkg::sector_t  sector;

	// Missing high bits of red read as zero, extra pixel bits are dropped.
	assign px_wide = {{(3*W){1'b0}}, pixel};
	assign px      = px_wide[3*W-1:0];
	assign r = px[3*W-1:2*W];
	assign g = px[2*W-1:W];
	assign b = px[W-1:0];

	always_comb begin
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		// Ties go to red, then green.
		if (r >= g && r >= b) begin
			sector = hsvcc_pkg::SEC_RED;
			mx     = r;
			diff   = $signed({1'b0, g}) - $signed({1'b0, b});
		end else if (g >= b) begin
			sector = hsvcc_pkg::SEC_GREEN;
			mx     = g;
			diff   = $signed({1'b0, b}) - $signed({1'b0, r});
		end else begin
			sector = hsvcc_pkg::SEC_BLUE;
			mx     = b;
			diff   = $signed({1'b0, r}) - $signed({1'b0, g});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1     <= mx;
			d_s1      <= mx - mn;
			diff_s1   <= diff;
			sector_s1 <= sector;
		end
	end
endmodule

@@ sv/hsvcc_hue.sv @@
// Stage 2: hue numerator over delta, saturation and value tests.
module hsvcc_hue #(
	parameter int CHANNEL_BITS = hsvcc_pkg::CHANNEL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_s1,
	input  logic [CHANNEL_BITS-1:0]       mx_s1,
	input  logic [CHANNEL_BITS-1:0]       d_s1,
	input  logic signed [CHANNEL_BITS:0]  diff_s1,
	input  hsvcc_pkg::sector_t            sector_s1,
	output logic                          valid_s2,
	output logic [CHANNEL_BITS+8:0]       hue_s2,
	output logic [CHANNEL_BITS-1:0]       d_s2,
	output hsvcc_pkg::gate_t              gate_s2
);
	localparam int W  = CHANNEL_BITS;
	localparam int HW = W + 9;
	localparam int SW = W + 4;
	localparam int VW = W + 7;
	localparam logic [VW-1:0] FULL = VW'((1 << W) - 1);

	localparam logic signed [HW:0] K_SECTOR = (HW+1)'(hsvcc_pkg::HUE_SECTOR);
	localparam logic signed [HW:0] K_GREEN  = (HW+1)'(hsvcc_pkg::HUE_GREEN_BASE);
	localparam logic signed [HW:0] K_BLUE   = (HW+1)'(hsvcc_pkg::HUE_BLUE_BASE);
	localparam logic signed [HW:0] K_WRAP   = (HW+1)'(hsvcc_pkg::HUE_WRAP);

	logic signed [HW:0] d_sx, diff_sx, base, h_raw, h_fix;
	logic [SW-1:0]      d_sw, mx_sw;
	logic [VW-1:0]      mx_vw;
	hsvcc_pkg::gate_t   gate;

	assign d_sx    = signed'((HW+1)'(d_s1));
	assign diff_sx = (HW+1)'(diff_s1);

	always_comb begin
		unique case (sector_s1)
			hsvcc_pkg::SEC_GREEN: base = K_GREEN * d_sx;
			hsvcc_pkg::SEC_BLUE:  base = K_BLUE * d_sx;
			default:              base = '0;
		endcase
		h_raw = base + K_SECTOR * diff_sx;
		// Wrap a negative red-sector hue into range.
		if (h_raw < 0) h_fix = h_raw + K_WRAP * d_sx;
		else           h_fix = h_raw;
	end

	assign d_sw  = SW'(d_s1);
	assign mx_sw = SW'(mx_s1);
	assign mx_vw = VW'(mx_s1);

	always_comb begin
		gate.nonzero    = (d_s1 != '0);
		gate.sat_hi     = (d_sw * SW'(10)) >= (mx_sw * SW'(6));
		gate.sat_mid    = (d_sw * SW'(2)) >= mx_sw;
		gate.val_yellow = (mx_vw * VW'(10)) >= (VW'(4) * FULL);
		gate.val_blue   = (mx_vw * VW'(100)) >= (VW'(15) * FULL);
		gate.val_orange = (mx_vw * VW'(10)) >= (VW'(3) * FULL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s2  <= h_fix[HW-1:0];
			d_s2    <= d_s1;
			gate_s2 <= gate;
		end
	end
endmodule

@@ sv/hsvcc_decide.sv @@
// Stage 3: hue window checks against scaled limits and class priority.
module hsvcc_decide #(
	parameter int CHANNEL_BITS = hsvcc_pkg::CHANNEL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_s2,
	input  logic [CHANNEL_BITS+8:0]       hue_s2,
	input  logic [CHANNEL_BITS-1:0]       d_s2,
	input  hsvcc_pkg::gate_t              gate_s2,
	output logic                          valid_s3,
	output hsvcc_pkg::color_class_t       class_s3
);
	localparam int HW = CHANNEL_BITS + 9;

	logic [HW-1:0]           d_hw;
	logic                    in_yellow, in_blue, in_orange;
	hsvcc_pkg::color_class_t cls;

	function automatic logic hue_in(logic [HW-1:0] h, logic [HW-1:0] dd, int lo, int hi);
		logic [HW-1:0] lo_b, hi_b;
		lo_b = dd * HW'(lo);
		hi_b = dd * HW'(hi);
		return (h >= lo_b) && (h <= hi_b);
	endfunction

	assign d_hw = HW'(d_s2);

	assign in_yellow = hue_in(hue_s2, d_hw, hsvcc_pkg::HUE_YELLOW_LO, hsvcc_pkg::HUE_YELLOW_HI);
	assign in_blue   = hue_in(hue_s2, d_hw, hsvcc_pkg::HUE_BLUE_LO, hsvcc_pkg::HUE_BLUE_HI);
	assign in_orange = hue_in(hue_s2, d_hw, hsvcc_pkg::HUE_ORANGE_LO, hsvcc_pkg::HUE_ORANGE_HI);

	always_comb begin
		cls = hsvcc_pkg::CLS_UNKNOWN;
		if (gate_s2.nonzero) begin
			if (in_yellow && gate_s2.sat_hi && gate_s2.val_yellow)
				cls = hsvcc_pkg::CLS_YELLOW;
			else if (in_blue && gate_s2.sat_hi && gate_s2.val_blue)
				cls = hsvcc_pkg::CLS_BLUE;
			else if (in_orange && gate_s2.sat_mid && gate_s2.val_orange)
				cls = hsvcc_pkg::CLS_ORANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			class_s3 <= cls;
		end
	end
endmodule

@@ sv/hsv_color_classifier.sv @@
// Top level: three-stage pixel to color class pipeline with valid/ready channels.
// A taken pixel passes through the stage 1, stage 2 and stage 3 registers, the last being the
// output register; throughput: one per cycle while the output is taken.
// Each stage register moves when it is empty or the stage after it moves, so a
// stalled output still lets bubbles upstream fill; ready goes low only when all
// three stages hold an item and the output is not taken.
module hsv_color_classifier #(
	parameter int CHANNEL_BITS = hsvcc_pkg::CHANNEL_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hsvcc_pixel_if.sink          pixel_ch,
	hsvcc_class_if.source        class_ch
);
	// Reset (arst_n low) clears the stage valid bits at once; data registers are not reset.
	localparam int W = CHANNEL_BITS;

	// Stage enables, driven from the output back.
	logic en1, en2, en3;

	// Stage 1: extrema and sector.
	logic                    valid_s1;
	logic [W-1:0]            mx_s1, d_s1;
	logic signed [W:0]       diff_s1;
	hsvcc_pkg::sector_t      sector_s1;

	// Stage 2: scaled hue and threshold gates.
	logic                    valid_s2;
	logic [W+8:0]            hue_s2;
	logic [W-1:0]            d_s2;
	hsvcc_pkg::gate_t        gate_s2;

	// Stage 3: final class, this is the output register.
	logic                    valid_s3;
	hsvcc_pkg::color_class_t class_s3;

	// A stage advances when it is empty or its successor advances.
	assign en3 = !valid_s3 || class_ch.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign pixel_ch.ready       = en1;
	assign class_ch.valid       = valid_s3;
	assign class_ch.color_class = class_s3;

	hsvcc_extrema #(.CHANNEL_BITS(CHANNEL_BITS)) u_extrema (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en1),
		.valid_in  (pixel_ch.valid),
		.pixel     (pixel_ch.pixel),
		.valid_s1  (valid_s1),
		.mx_s1     (mx_s1),
		.d_s1      (d_s1),
		.diff_s1   (diff_s1),
		.sector_s1 (sector_s1)
	);

	hsvcc_hue #(.CHANNEL_BITS(CHANNEL_BITS)) u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en2),
		.valid_s1  (valid_s1),
		.mx_s1     (mx_s1),
		.d_s1      (d_s1),
		.diff_s1   (diff_s1),
		.sector_s1 (sector_s1),
		.valid_s2  (valid_s2),
		.hue_s2    (hue_s2),
		.d_s2      (d_s2),
		.gate_s2   (gate_s2)
	);

	hsvcc_decide #(.CHANNEL_BITS(CHANNEL_BITS)) u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en3),
		.valid_s2  (valid_s2),
		.hue_s2    (hue_s2),
		.d_s2      (d_s2),
		.gate_s2   (gate_s2),
		.valid_s3  (valid_s3),
		.class_s3  (class_s3)
	);

	// Input backpressure only when the whole pipe is full and the output stalls.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ch.ready |-> (valid_s1 && valid_s2 && valid_s3 && !class_ch.ready))
		else $error("input stalled while the pipeline had room");

	// An item in stage 2 moves into the output register when the output is taken.
	a_s2_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && class_ch.ready && valid_s2) |=> valid_s3)
		else $error("stage 2 item lost on output handoff");

	// An accepted pixel occupies stage 1 on the next cycle.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_ch.valid && pixel_ch.ready) |=> valid_s1)
		else $error("accepted pixel did not enter stage 1");
endmodule

@@ tb/hsv_color_classifier_test.sv @@
// Self-checking testbench of the HSV color classifier: directed table, then random pixels.
module hsv_color_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FULL_SCALE   = (1 << hsvcc_pkg::CHANNEL_BITS) - 1;
	localparam int RANDOM_ITEMS = 1900;
	// The tail of the run goes without idling on either side.
	localparam int CALM_ITEMS   = 200;
	localparam int MAX_REPORTS  = 10;
	// Pipeline depth is three; drain a few more cycles before the verdict.
	localparam int DRAIN_CYCLES = 8;

	// One row of the directed table. Where typed is set, cls is the known class;
	// otherwise the row is checked against the predictor.
	typedef struct packed {
		logic [hsvcc_pkg::PIXEL_BITS-1:0] pixel;
		logic                             typed;
		hsvcc_pkg::color_class_t          cls;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 28;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Extremes and the simple cases, class known at a glance.
		{24'h000000, 1'b1, hsvcc_pkg::CLS_UNKNOWN},  // black: zero max
		{24'hFFFFFF, 1'b1, hsvcc_pkg::CLS_UNKNOWN},  // white: zero delta
		{24'h808080, 1'b1, hsvcc_pkg::CLS_UNKNOWN},  // grey: zero delta
		{24'hFF0000, 1'b1, hsvcc_pkg::CLS_UNKNOWN},  // pure red, hue 0
		{24'h00FF00, 1'b1, hsvcc_pkg::CLS_UNKNOWN},  // pure green, hue 120
		{24'hFF0080, 1'b1, hsvcc_pkg::CLS_UNKNOWN},  // red sector below zero, wraps to 330
		{24'hFFFF00, 1'b1, hsvcc_pkg::CLS_YELLOW},   // red and green tie, red wins, hue 60
		{24'h0000FF, 1'b1, hsvcc_pkg::CLS_BLUE},     // pure blue, hue 240
		{24'hFF6600, 1'b1, hsvcc_pkg::CLS_ORANGE},   // hue 24
		{24'h00FFFF, 1'b1, hsvcc_pkg::CLS_UNKNOWN},  // green and blue tie, green wins, hue 180
		// Limits of hue, saturation and value, one step either side.
		{24'hFFA600, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // yellow low hue, just in
		{24'hFFA500, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // just out
		{24'hD5FF00, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // yellow high hue, green sector, just in
		{24'hD4FF00, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // just out
		{24'h00AAFF, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // blue low hue, just in
		{24'h00ABFF, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // just out
		{24'h9400FF, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // blue high hue, just in
		{24'h9500FF, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // just out
		{24'hFF1E00, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // orange low hue, just in
		{24'hFF1D00, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // just out
		{24'hFF7700, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // orange high hue, just in
		{24'hFF7800, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // just out
		{24'h000027, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // blue value limit, just in
		{24'h000026, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // just out
		{24'h666600, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // yellow value limit, just in
		{24'h656500, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // just out
		{24'hFFFF66, 1'b0, hsvcc_pkg::CLS_UNKNOWN},  // yellow saturation limit, just in
		{24'hFEA980, 1'b0, hsvcc_pkg::CLS_UNKNOWN}   // orange saturation limit, just out
	};

	logic clk = 1'b0;
	logic arst_n;
	logic calm = 1'b0;
	int   mismatches = 0;

	// Classes still owed by the block, oldest first, with the pixels that caused them.
	hsvcc_pkg::color_class_t          pending_classes [$];
	logic [hsvcc_pkg::PIXEL_BITS-1:0] pending_pixels [$];

	hsvcc_pixel_if pixel_ch ();
	hsvcc_class_if class_ch ();

	hsv_color_classifier uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel_ch (pixel_ch),
		.class_ch (class_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Classify one pixel the way the block must: split into channels, form hue as a
	// numerator over delta, and compare every fraction by cross-multiplying.
	function automatic hsvcc_pkg::color_class_t classify_pixel(
		input logic [hsvcc_pkg::PIXEL_BITS-1:0] px
	);
		longint unsigned wide;
		int red, grn, blu, hi, lo, delta, hue_num;
		hsvcc_pkg::color_class_t cls;
		// Missing high bits of red read as zero when the channels overrun the field.
		wide = px;
		red = int'((wide >> (2 * hsvcc_pkg::CHANNEL_BITS)) & FULL_SCALE);
		grn = int'((wide >> hsvcc_pkg::CHANNEL_BITS) & FULL_SCALE);
		blu = int'(wide & FULL_SCALE);
		hi = red;
		lo = red;
		if (grn > hi) hi = grn;
		if (blu > hi) hi = blu;
		if (grn < lo) lo = grn;
		if (blu < lo) lo = blu;
		delta = hi - lo;
		cls = hsvcc_pkg::CLS_UNKNOWN;
		// Zero delta covers grey and black: hue and saturation are zero, so unknown.
		if (delta > 0) begin
			// Ties pick red first, then green.
			if (hi == red) begin
				hue_num = hsvcc_pkg::HUE_SECTOR * (grn - blu);
				if (hue_num < 0) hue_num += hsvcc_pkg::HUE_WRAP * delta;
			end else if (hi == grn) begin
				hue_num = hsvcc_pkg::HUE_GREEN_BASE * delta +
					hsvcc_pkg::HUE_SECTOR * (blu - red);
			end else begin
				hue_num = hsvcc_pkg::HUE_BLUE_BASE * delta +
					hsvcc_pkg::HUE_SECTOR * (red - grn);
			end
			// S >= 0.6 is 10*D >= 6*M; V >= x is M*den >= num*F.
			if (hue_num >= hsvcc_pkg::HUE_YELLOW_LO * delta &&
					hue_num <= hsvcc_pkg::HUE_YELLOW_HI * delta &&
					10 * delta >= 6 * hi && 10 * hi >= 4 * FULL_SCALE) begin
				cls = hsvcc_pkg::CLS_YELLOW;
			end else if (hue_num >= hsvcc_pkg::HUE_BLUE_LO * delta &&
					hue_num <= hsvcc_pkg::HUE_BLUE_HI * delta &&
					10 * delta >= 6 * hi && 100 * hi >= 15 * FULL_SCALE) begin
				cls = hsvcc_pkg::CLS_BLUE;
			end else if (hue_num >= hsvcc_pkg::HUE_ORANGE_LO * delta &&
					hue_num <= hsvcc_pkg::HUE_ORANGE_HI * delta &&
					2 * delta >= hi && 10 * hi >= 3 * FULL_SCALE) begin
				cls = hsvcc_pkg::CLS_ORANGE;
			end
		end
		return cls;
	endfunction

	// Pixel source: reset, walk the directed table, then random pixels. Record the
	// owed class at the edge where the item is taken, and give the verdict at the end.
	initial begin : feed_pixels
		int total;
		int k;
		logic [hsvcc_pkg::PIXEL_BITS-1:0]   px;
		logic [hsvcc_pkg::CHANNEL_BITS-1:0] ch_hi, ch_mid, ch_lo;
		hsvcc_pkg::color_class_t want;
		arst_n <= 1'b0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.pixel <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		total = DIRECTED_ROWS + RANDOM_ITEMS;
		for (k = 0; k < total; k++) begin
			if (k < DIRECTED_ROWS) begin
				px = DIRECTED[k].pixel;
			end else if ($urandom_range(0, 1) == 0) begin
				// Uniform noise: toggles every bit of the field.
				px = hsvcc_pkg::PIXEL_BITS'($urandom);
			end else begin
				// Build a colorful pixel: pick max, min and middle, then a channel order,
				// so the class limits are hit far more often than by noise alone.
				ch_hi  = hsvcc_pkg::CHANNEL_BITS'($urandom_range(0, FULL_SCALE));
				ch_lo  = hsvcc_pkg::CHANNEL_BITS'($urandom_range(0, ch_hi));
				ch_mid = hsvcc_pkg::CHANNEL_BITS'($urandom_range(ch_lo, ch_hi));
				case ($urandom_range(0, 5))
					0: px = {ch_hi, ch_mid, ch_lo};
					1: px = {ch_hi, ch_lo, ch_mid};
					2: px = {ch_mid, ch_hi, ch_lo};
					3: px = {ch_lo, ch_hi, ch_mid};
					4: px = {ch_mid, ch_lo, ch_hi};
					default: px = {ch_lo, ch_mid, ch_hi};
				endcase
			end
			if (k >= total - CALM_ITEMS) calm = 1'b1;
			// Drop valid for a burst now and then.
			if (!calm && $urandom_range(0, 3) == 0) begin
				pixel_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			pixel_ch.valid <= 1'b1;
			pixel_ch.pixel <= px;
			// Hold the item until the block takes it.
			@(posedge clk);
			while (!pixel_ch.ready) @(posedge clk);
			if (k < DIRECTED_ROWS && DIRECTED[k].typed) begin
				want = hsvcc_pkg::color_class_t'(DIRECTED[k].cls);
			end else begin
				want = classify_pixel(px);
			end
			pending_classes.push_back(want);
			pending_pixels.push_back(px);
		end
		pixel_ch.valid <= 1'b0;
		// Wait for every owed class, then let the pipeline run dry.
		while (pending_classes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Result sink: stall in random bursts, hold ready high once the run is calm.
	initial begin : drain_classes
		class_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				class_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				class_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Compare each taken class with the oldest one owed.
	always @(posedge clk) begin : check_classes
		hsvcc_pkg::color_class_t          want;
		logic [hsvcc_pkg::PIXEL_BITS-1:0] px;
		if (arst_n === 1'b1 && class_ch.valid === 1'b1 && class_ch.ready === 1'b1) begin
			if (pending_classes.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("class %0d came with no pixel in flight", class_ch.color_class);
				mismatches++;
			end else begin
				want = pending_classes.pop_front();
				px = pending_pixels.pop_front();
				if (class_ch.color_class !== want) begin
					if (mismatches < MAX_REPORTS)
						$display("pixel %06h: expected class %0d, got %0d",
							px, want, class_ch.color_class);
					mismatches++;
				end
			end
		end
	end

	// Give up after far longer than the slowest correct run.
	initial begin : watchdog
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
